FILE: src/mvs_pkg.sv
// Shared constants and types for the measurement value scaler.
`default_nettype none
package mvs_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VALUE_BITS    = 37;
	localparam int NUM_BITS      = 29;  // signed numerator of every formula
	localparam int DEN_BITS      = 17;  // largest constant divisor is 91000
	localparam int DIV_BITS      = DEN_BITS + 1;

	localparam logic [4:0] U_END   = 5'd0;
	localparam logic [4:0] U_RPM   = 5'd1;
	localparam logic [4:0] U_PCT   = 5'd2;
	localparam logic [4:0] U_DEG   = 5'd3;
	localparam logic [4:0] U_CEL   = 5'd4;
	localparam logic [4:0] U_VOLT  = 5'd5;
	localparam logic [4:0] U_KMH   = 5'd6;
	localparam logic [4:0] U_OHM   = 5'd7;
	localparam logic [4:0] U_MM    = 5'd8;
	localparam logic [4:0] U_BAR   = 5'd9;
	localparam logic [4:0] U_MSEC  = 5'd10;
	localparam logic [4:0] U_MBAR  = 5'd11;
	localparam logic [4:0] U_AMP   = 5'd12;
	localparam logic [4:0] U_DEGKW = 5'd13;
	localparam logic [4:0] U_KW    = 5'd14;
	localparam logic [4:0] U_LPH   = 5'd15;
	localparam logic [4:0] U_KM    = 5'd16;
	localparam logic [4:0] U_MGH   = 5'd17;
	localparam logic [4:0] U_AH    = 5'd18;
	localparam logic [4:0] U_TIME  = 5'd19;
	localparam logic [4:0] U_NM    = 5'd20;
	localparam logic [4:0] U_SEC   = 5'd21;
	localparam logic [4:0] U_MS2   = 5'd22;
	localparam logic [4:0] U_CHARS = 5'd23;
	localparam logic [4:0] U_GS    = 5'd24;
	localparam logic [4:0] U_DPS   = 5'd25;
	localparam logic [4:0] U_NONE  = 5'd26;
	localparam logic [4:0] U_UNK   = 5'd27;

	typedef struct packed {
		logic [7:0] formula;
		logic [7:0] a;
		logic [7:0] b;
		logic [4:0] unit;
		logic       neg;
	} mvs_meta_t;
endpackage
`default_nettype wire

FILE: src/measurement_value_scaler.sv
// Top level: formula decode, pipelined rounding divider and saturation.
// Usage: drive formula/byte_a/byte_b with start high for one transaction per
// cycle; busy is always low, so every start is taken. Each transaction yields
// exactly one result on value/unit/echo ports, marked by done for one cycle.
// The pipeline has one decode stage, one numerator setup
// stage, FRAC_BITS + 29 restoring-divider stages (one quotient bit each),
// and the output register. Throughput is one transaction per cycle; the
// divider depth sets the latency. Results come out in input order.
// Reset clears all valid bits, dropping transactions in flight; done stays
// low until new transactions reach the output. The receiver cannot stall,
// so no back pressure exists anywhere in the pipeline.
// value is signed fixed point with FRAC_BITS fraction bits, rounded to
// nearest (ties away from zero), saturated to 37 bits. Unknown formulas
// give value 0 with the unknown unit code.
// Formulas dividing by byte a use divisor 1 when a is zero.
`default_nettype none
module measurement_value_scaler #(
	parameter int FRAC_BITS = mvs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [7:0]                      formula,
	input  wire logic [7:0]                      byte_a,
	input  wire logic [7:0]                      byte_b,
	output logic                                 done,
	output logic signed [mvs_pkg::VALUE_BITS-1:0] value,
	output logic [4:0]                           unit,
	output logic [7:0]                           formula_echo,
	output logic [7:0]                           a_echo,
	output logic [7:0]                           b_echo
);
	import mvs_pkg::*;

	localparam int NW = NUM_BITS + FRAC_BITS;  // numerator/quotient width
	localparam logic [NW-1:0] LIM_POS = NW'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
	localparam logic [NW-1:0] LIM_NEG = NW'(64'd1 << (VALUE_BITS - 1));

	assign busy = 1'b0;

	// ---------------- stage 1: formula decode ----------------
	logic signed [NUM_BITS-1:0] sa, sb, sw, n_c;
	logic [DEN_BITS-1:0] d_c, a_den;
	logic [4:0] u_c;

	always_comb begin
		sa = NUM_BITS'(signed'({1'b0, byte_a}));
		sb = NUM_BITS'(signed'({1'b0, byte_b}));
		sw = NUM_BITS'(signed'({1'b0, byte_a, byte_b}));
		a_den = (byte_a == 8'd0) ? DEN_BITS'(1) : DEN_BITS'(byte_a);
		n_c = '0;
		d_c = DEN_BITS'(1);
		u_c = U_UNK;
		case (formula)
			8'd1: begin n_c = sa * sb; d_c = 17'd5; u_c = U_RPM; end
			8'd2: begin n_c = sa * sb; d_c = 17'd500; u_c = U_PCT; end
			8'd3: begin n_c = sa * sb; d_c = 17'd500; u_c = U_DEG; end
			8'd4: begin
				n_c = ((sb >= 29'sd127) ? sb - 29'sd127 : 29'sd127 - sb) * sa;
				d_c = 17'd100; u_c = U_UNK;
			end
			8'd5: begin n_c = sa * (sb - 29'sd100); d_c = 17'd10; u_c = U_CEL; end
			8'd6: begin n_c = sa * sb; d_c = 17'd1000; u_c = U_VOLT; end
			8'd7: begin n_c = sa * sb; d_c = 17'd100; u_c = U_KMH; end
			8'd8: begin n_c = sa * sb; d_c = 17'd10; u_c = U_NONE; end
			8'd9: begin n_c = (sb - 29'sd127) * sa; d_c = 17'd50; u_c = U_DEG; end
			8'd10: begin n_c = sb; u_c = U_NONE; end
			8'd11: begin
				n_c = sa * (sb - 29'sd128) + 29'sd10000;
				d_c = 17'd10000; u_c = U_NONE;
			end
			8'd12: begin n_c = sa * sb; d_c = 17'd1000; u_c = U_OHM; end
			8'd13: begin n_c = (sb - 29'sd127) * sa; d_c = 17'd1000; u_c = U_MM; end
			8'd14: begin n_c = sa * sb; d_c = 17'd200; u_c = U_BAR; end
			8'd15: begin n_c = sa * sb; d_c = 17'd100; u_c = U_MSEC; end
			8'd16: u_c = U_UNK;
			8'd17: u_c = U_CHARS;
			8'd18: begin n_c = sa * sb; d_c = 17'd25; u_c = U_MBAR; end
			8'd19: begin n_c = sa * sb; d_c = 17'd100; u_c = U_UNK; end
			8'd20: begin n_c = sa * (sb - 29'sd128); d_c = 17'd128; u_c = U_PCT; end
			8'd21: begin n_c = sa * sb; d_c = 17'd1000; u_c = U_VOLT; end
			8'd22: begin n_c = sa * sb; d_c = 17'd1000; u_c = U_MSEC; end
			8'd23: begin n_c = sa * sb; d_c = 17'd256; u_c = U_PCT; end
			8'd24: begin n_c = sa * sb; d_c = 17'd1000; u_c = U_AMP; end
			8'd25: begin
				n_c = 29'sd129311 * sb + 29'sd500 * sa;
				d_c = 17'd91000; u_c = U_UNK;
			end
			8'd26: begin n_c = sb - sa; u_c = U_UNK; end
			8'd27: begin
				n_c = ((sb >= 29'sd128) ? sb - 29'sd128 : 29'sd128 - sb) * sa;
				d_c = 17'd100; u_c = U_UNK;
			end
			8'd28: begin n_c = sb - sa; u_c = U_NONE; end
			8'd29: begin n_c = (sb < sa) ? 29'sd1 : 29'sd0; u_c = U_UNK; end
			8'd30: begin n_c = sa * sb; d_c = 17'd12; u_c = U_DEGKW; end
			8'd31: begin n_c = sa * sb; d_c = 17'd2560; u_c = U_CEL; end
			8'd32: begin n_c = (sb > 29'sd128) ? sb - 29'sd256 : sb; u_c = U_NONE; end
			8'd33: begin n_c = 29'sd100 * sb; d_c = a_den; u_c = U_PCT; end
			8'd34: begin n_c = (sb - 29'sd128) * sa; d_c = 17'd100; u_c = U_KW; end
			8'd35: begin n_c = sa * sb; d_c = 17'd100; u_c = U_LPH; end
			8'd36: begin n_c = 29'sd2560 * sa + 29'sd10 * sb; u_c = U_KM; end
			8'd38: begin n_c = (sb - 29'sd128) * sa; d_c = 17'd1000; u_c = U_DEGKW; end
			8'd39: begin n_c = sa * sb; d_c = 17'd256; u_c = U_MGH; end
			8'd40: begin
				n_c = sb + 29'sd2550 * sa - 29'sd40000;
				d_c = 17'd100; u_c = U_AMP;
			end
			8'd41: begin n_c = sb + 29'sd255 * sa; u_c = U_AH; end
			8'd42: begin
				n_c = sb + 29'sd255 * sa - 29'sd4000;
				d_c = 17'd10; u_c = U_UNK;
			end
			8'd43: begin n_c = sb + 29'sd255 * sa; d_c = 17'd10; u_c = U_VOLT; end
			8'd44: u_c = U_TIME;
			8'd45: begin n_c = sa * sb; d_c = 17'd1000; u_c = U_NONE; end
			8'd46: begin
				n_c = (sa * sb - 29'sd3200) * 29'sd27;
				d_c = 17'd10000; u_c = U_DEGKW;
			end
			8'd47: begin n_c = (sb - 29'sd128) * sa; u_c = U_MSEC; end
			8'd48: begin n_c = sb + 29'sd255 * sa; u_c = U_NONE; end
			8'd49: begin n_c = sa * sb; d_c = 17'd40; u_c = U_MGH; end
			8'd50: begin n_c = (sb - 29'sd128) * 29'sd100; d_c = a_den; u_c = U_MBAR; end
			8'd51: begin n_c = (sb - 29'sd128) * sa; d_c = 17'd255; u_c = U_MGH; end
			8'd52: begin n_c = sa * sb - 29'sd50 * sa; d_c = 17'd50; u_c = U_NM; end
			8'd53: begin
				n_c = 29'sd14222 * (sb - 29'sd128) + 29'sd60 * sa;
				d_c = 17'd10000; u_c = U_GS;
			end
			8'd54: begin n_c = sw; u_c = U_NONE; end
			8'd55: begin n_c = sa * sb; d_c = 17'd200; u_c = U_SEC; end
			8'd56: begin n_c = sw; u_c = U_UNK; end
			8'd57: begin n_c = sw + 29'sd65536; u_c = U_UNK; end
			8'd58: begin
				n_c = 29'sd10225 * ((sb > 29'sd128) ? 29'sd256 - sb : sb);
				d_c = 17'd10000; u_c = U_UNK;
			end
			8'd59: begin n_c = sw; d_c = 17'd32768; u_c = U_NONE; end
			8'd60: begin n_c = sw; d_c = 17'd100; u_c = U_SEC; end
			8'd61: begin n_c = sb - 29'sd128; d_c = a_den; u_c = U_NONE; end
			8'd62: begin n_c = 29'sd32 * sa * sb; d_c = 17'd125; u_c = U_UNK; end
			8'd63: u_c = U_CHARS;
			8'd64: begin n_c = sa + sb; u_c = U_OHM; end
			8'd65: begin n_c = sa * (sb - 29'sd127); d_c = 17'd100; u_c = U_MM; end
			8'd66: begin n_c = 29'sd100 * sa * sb; d_c = 17'd51112; u_c = U_VOLT; end
			8'd67: begin n_c = 29'sd1280 * sa + 29'sd5 * sb; d_c = 17'd2; u_c = U_DEG; end
			8'd68: begin n_c = 29'sd1000 * sw; d_c = 17'd7365; u_c = U_DPS; end
			8'd69: begin n_c = 29'sd3254 * sw; d_c = 17'd10000; u_c = U_BAR; end
			8'd70: begin n_c = 29'sd192 * sw; d_c = 17'd1000; u_c = U_MS2; end
			default: begin n_c = '0; d_c = DEN_BITS'(1); u_c = U_UNK; end
		endcase
	end

	logic                       v_s1;
	logic signed [NUM_BITS-1:0] n_s1;
	logic [DEN_BITS-1:0]        d_s1;
	mvs_meta_t                  m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		n_s1 <= n_c;
		d_s1 <= d_c;
		m_s1 <= '{formula: formula, a: byte_a, b: byte_b, unit: u_c, neg: 1'b0};
	end

	// ---------------- stage 2: magnitude and rounding offset ----------------
	// q = (2*|num|*2^F + d) / (2*d) rounds half away from zero
	logic [NUM_BITS-1:0] mag_c;
	logic                v_s2;
	logic [NW-1:0]       n_s2;
	logic [DIV_BITS-1:0] d_s2;
	mvs_meta_t           m_s2;

	assign mag_c = n_s1[NUM_BITS-1] ? NUM_BITS'(-n_s1) : NUM_BITS'(n_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		n_s2 <= {mag_c[NUM_BITS-2:0], {(FRAC_BITS + 1){1'b0}}} + NW'(d_s1);
		d_s2 <= {d_s1, 1'b0};
		m_s2 <= '{formula: m_s1.formula, a: m_s1.a, b: m_s1.b, unit: m_s1.unit,
			neg: n_s1[NUM_BITS-1]};
	end

	// ---------------- restoring divider, one quotient bit per stage ----------------
	logic                v_dv [0:NW];
	logic [NW-1:0]       n_dv [0:NW];
	logic [NW-1:0]       q_dv [0:NW];
	logic [DIV_BITS-1:0] r_dv [0:NW];
	logic [DIV_BITS-1:0] d_dv [0:NW];
	mvs_meta_t           m_dv [0:NW];

	assign v_dv[0] = v_s2;
	assign n_dv[0] = n_s2;
	assign q_dv[0] = '0;
	assign r_dv[0] = '0;
	assign d_dv[0] = d_s2;
	assign m_dv[0] = m_s2;

	for (genvar i = 0; i < NW; i++) begin : g_div
		logic [DIV_BITS:0] t;
		logic              ge;
		always_comb begin
			t  = {r_dv[i], n_dv[i][NW-1-i]};
			ge = (t >= {1'b0, d_dv[i]});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv[i+1] <= 1'b0;
			end else begin
				v_dv[i+1] <= v_dv[i];
			end
		end
		always_ff @(posedge clk) begin
			r_dv[i+1] <= ge ? DIV_BITS'(t - {1'b0, d_dv[i]}) : DIV_BITS'(t);
			q_dv[i+1] <= q_dv[i] | (NW'(ge) << (NW - 1 - i));
			n_dv[i+1] <= n_dv[i];
			d_dv[i+1] <= d_dv[i];
			m_dv[i+1] <= m_dv[i];
		end
	end

	// ---------------- output: saturate, apply sign ----------------
	logic [NW-1:0]           qs_c;
	logic [VALUE_BITS-1:0]   val_c;
	mvs_meta_t               m_out;

	assign m_out = m_dv[NW];

	always_comb begin
		if (m_out.neg) begin
			qs_c  = (q_dv[NW] > LIM_NEG) ? LIM_NEG : q_dv[NW];
			val_c = VALUE_BITS'(-qs_c);
		end else begin
			qs_c  = (q_dv[NW] > LIM_POS) ? LIM_POS : q_dv[NW];
			val_c = VALUE_BITS'(qs_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_dv[NW];
		end
	end

	always_ff @(posedge clk) begin
		value        <= signed'(val_c);
		unit         <= m_out.unit;
		formula_echo <= m_out.formula;
		a_echo       <= m_out.a;
		b_echo       <= m_out.b;
	end
endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the measurement value scaler.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mvs_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int LATENCY = FB + 32;

	typedef struct {
		logic signed [VALUE_BITS-1:0] value;
		logic [4:0] unit;
		logic [7:0] f;
		logic [7:0] a;
		logic [7:0] b;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [7:0] formula = '0, byte_a = '0, byte_b = '0;
	wire busy, done;
	wire signed [VALUE_BITS-1:0] value;
	wire [4:0] unit;
	wire [7:0] formula_echo, a_echo, b_echo;

	reading_t pending_readings[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int burst_left = 0;

	measurement_value_scaler u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.formula(formula), .byte_a(byte_a), .byte_b(byte_b), .done(done),
		.value(value), .unit(unit), .formula_echo(formula_echo),
		.a_echo(a_echo), .b_echo(b_echo)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("timeout at %0t", $time);
		$display("status: fail");
		$finish;
	end

	// exact ratio to fixed point, ties away from zero, saturating
	function automatic logic signed [VALUE_BITS-1:0] fixed_of(longint num, longint den);
		longint unsigned mag, q, lim;
		logic neg;
		begin
			neg = num < 0;
			mag = neg ? -num : num;
			q = ((mag << FB) * 2 + den) / (2 * den);
			lim = neg ? (64'd1 << (VALUE_BITS - 1)) : (64'd1 << (VALUE_BITS - 1)) - 1;
			if (q > lim)
				q = lim;
			return VALUE_BITS'(neg ? -$signed(q) : $signed(q));
		end
	endfunction

	function automatic reading_t scale_reading(logic [7:0] f, logic [7:0] ab, logic [7:0] bb);
		longint a, b, w, num, den;
		logic [4:0] u;
		reading_t r;
		begin
			a = longint'(ab); b = longint'(bb); w = 256 * a + b;
			num = 0; den = 1; u = U_UNK;
			case (f)
			1: begin num = a * b; den = 5; u = U_RPM; end
			2: begin num = a * b; den = 500; u = U_PCT; end
			3: begin num = a * b; den = 500; u = U_DEG; end
			4: begin num = (b >= 127 ? b - 127 : 127 - b) * a; den = 100; end
			5: begin num = a * (b - 100); den = 10; u = U_CEL; end
			6: begin num = a * b; den = 1000; u = U_VOLT; end
			7: begin num = a * b; den = 100; u = U_KMH; end
			8: begin num = a * b; den = 10; u = U_NONE; end
			9: begin num = (b - 127) * a; den = 50; u = U_DEG; end
			10: begin num = b; u = U_NONE; end
			11: begin num = a * (b - 128) + 10000; den = 10000; u = U_NONE; end
			12: begin num = a * b; den = 1000; u = U_OHM; end
			13: begin num = (b - 127) * a; den = 1000; u = U_MM; end
			14: begin num = a * b; den = 200; u = U_BAR; end
			15: begin num = a * b; den = 100; u = U_MSEC; end
			16: u = U_UNK;
			17: u = U_CHARS;
			18: begin num = a * b; den = 25; u = U_MBAR; end
			19: begin num = a * b; den = 100; end
			20: begin num = a * (b - 128); den = 128; u = U_PCT; end
			21: begin num = a * b; den = 1000; u = U_VOLT; end
			22: begin num = a * b; den = 1000; u = U_MSEC; end
			23: begin num = a * b; den = 256; u = U_PCT; end
			24: begin num = a * b; den = 1000; u = U_AMP; end
			25: begin num = 1421 * 91 * b + 500 * a; den = 91000; end
			26: num = b - a;
			27: begin num = (b >= 128 ? b - 128 : 128 - b) * a; den = 100; end
			28: begin num = b - a; u = U_NONE; end
			29: num = (b < a) ? 1 : 0;
			30: begin num = a * b; den = 12; u = U_DEGKW; end
			31: begin num = a * b; den = 2560; u = U_CEL; end
			32: begin num = (b > 128) ? b - 256 : b; u = U_NONE; end
			33: begin num = 100 * b; den = (a == 0) ? 1 : a; u = U_PCT; end
			34: begin num = (b - 128) * a; den = 100; u = U_KW; end
			35: begin num = a * b; den = 100; u = U_LPH; end
			36: begin num = 2560 * a + 10 * b; u = U_KM; end
			38: begin num = (b - 128) * a; den = 1000; u = U_DEGKW; end
			39: begin num = a * b; den = 256; u = U_MGH; end
			40: begin num = b + 2550 * a - 40000; den = 100; u = U_AMP; end
			41: begin num = b + 255 * a; u = U_AH; end
			42: begin num = b + 255 * a - 4000; den = 10; end
			43: begin num = b + 255 * a; den = 10; u = U_VOLT; end
			44: u = U_TIME;
			45: begin num = a * b; den = 1000; u = U_NONE; end
			46: begin num = (a * b - 3200) * 27; den = 10000; u = U_DEGKW; end
			47: begin num = (b - 128) * a; u = U_MSEC; end
			48: begin num = b + 255 * a; u = U_NONE; end
			49: begin num = a * b; den = 40; u = U_MGH; end
			50: begin num = (b - 128) * 100; den = (a == 0) ? 1 : a; u = U_MBAR; end
			51: begin num = (b - 128) * a; den = 255; u = U_MGH; end
			52: begin num = a * b - 50 * a; den = 50; u = U_NM; end
			53: begin num = 14222 * (b - 128) + 60 * a; den = 10000; u = U_GS; end
			54: begin num = w; u = U_NONE; end
			55: begin num = a * b; den = 200; u = U_SEC; end
			56: num = w;
			57: num = w + 65536;
			58: begin num = 10225 * ((b > 128) ? 256 - b : b); den = 10000; end
			59: begin num = w; den = 32768; u = U_NONE; end
			60: begin num = w; den = 100; u = U_SEC; end
			61: begin num = b - 128; den = (a == 0) ? 1 : a; u = U_NONE; end
			62: begin num = 32 * a * b; den = 125; end
			63: u = U_CHARS;
			64: begin num = a + b; u = U_OHM; end
			65: begin num = a * (b - 127); den = 100; u = U_MM; end
			66: begin num = 100 * a * b; den = 51112; u = U_VOLT; end
			67: begin num = 1280 * a + 5 * b; den = 2; u = U_DEG; end
			68: begin num = 1000 * w; den = 7365; u = U_DPS; end
			69: begin num = 3254 * w; den = 10000; u = U_BAR; end
			70: begin num = 192 * w; den = 1000; u = U_MS2; end
			default: u = U_UNK;
			endcase
			r.value = fixed_of(num, den);
			r.unit = u; r.f = f; r.a = ab; r.b = bb;
			return r;
		end
	endfunction

	// sender works in bursts; bursts may be separated by idle gaps
	task automatic send_triple(logic [7:0] f, logic [7:0] a, logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		start <= 1'b1;
		formula <= f;
		byte_a <= a;
		byte_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_readings.push_back(scale_reading(f, a, b));
		sent++;
	endtask

	always @(posedge clk) begin
		reading_t exp_r;
		if (done) begin
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result f=%0d", $time, formula_echo);
				errors++;
			end else begin
				exp_r = pending_readings.pop_front();
				checked++;
				if (value !== exp_r.value || unit !== exp_r.unit || formula_echo !== exp_r.f
						|| a_echo !== exp_r.a || b_echo !== exp_r.b) begin
					$display("%0t: mismatch exp v=%0d u=%0d f=%0d a=%0d b=%0d", $time,
						exp_r.value, exp_r.unit, exp_r.f, exp_r.a, exp_r.b);
					$display("%0t:          got v=%0d u=%0d f=%0d a=%0d b=%0d", $time,
						value, unit, formula_echo, a_echo, b_echo);
					errors++;
				end
			end
		end
	end

	task automatic test_extremes();
		logic [7:0] vals[4] = '{8'd0, 8'd1, 8'd128, 8'd255};
		for (int i = 0; i < 4; i++)
			send_triple(8'd70, vals[i], vals[3 - i]);
		send_triple(8'd0, 8'd255, 8'd255);
		send_triple(8'd37, 8'd12, 8'd34);
		send_triple(8'd71, 8'd255, 8'd0);
		send_triple(8'd255, 8'd170, 8'd85);
		send_triple(8'd16, 8'd9, 8'd9);
		send_triple(8'd17, 8'd9, 8'd9);
		send_triple(8'd44, 8'd9, 8'd9);
		send_triple(8'd63, 8'd9, 8'd9);
		// divide-by-a with a == 0
		send_triple(8'd33, 8'd0, 8'd255);
		send_triple(8'd50, 8'd0, 8'd0);
		send_triple(8'd61, 8'd0, 8'd0);
		// rounding and sign: two negative fractions and one large integer
		send_triple(8'd61, 8'd255, 8'd127);
		send_triple(8'd9, 8'd255, 8'd0);
		send_triple(8'd57, 8'd255, 8'd255);
	endtask

	task automatic test_every_formula();
		for (int f = 1; f <= 70; f++)
			send_triple(f[7:0], 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic test_random();
		logic [7:0] f;
		for (int i = 0; i < 410; i++) begin
			f = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(1, 70));
			case ($urandom_range(0, 5))
			0: send_triple(f, $urandom_range(0, 1) ? 8'd0 : 8'd255,
				8'($urandom_range(0, 255)));
			1: send_triple(f, 8'($urandom_range(0, 255)), 8'($urandom_range(126, 129)));
			default: send_triple(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_every_formula();
		test_random();
		start <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		$display("sent %0d transactions, checked %0d results", sent, checked);
		$display("covered all 70 formulas, unassigned codes, a==0 divisors, byte extremes");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

FILE: measurement_value_scaler.f
src/mvs_pkg.sv
src/measurement_value_scaler.sv
sim/testbench.sv
